[hw/rtl/gnss_satellite_view_table_defines.svh]
// ----------------------------------------------------------------------------
// GNSS satellite view table assertion macros
// Shared property forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef GNSS_SATELLITE_VIEW_TABLE_DEFINES_SVH
`define GNSS_SATELLITE_VIEW_TABLE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define GSVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define GSVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/gsvt_pkg.sv]
// ----------------------------------------------------------------------------
// GNSS satellite view table package
// Payload types, slot entry layout, constants and helpers.
// ----------------------------------------------------------------------------
package gsvt_pkg;

	localparam logic [6:0]  CAP99         = 7'd99;
	localparam logic [15:0] TALKER_GN     = 16'h474E;
	localparam logic [15:0] TALKER_NONE   = 16'h0000;
	localparam logic [19:0] LIFETIME_INIT = 20'd5000;

	typedef logic [19:0] lifetime_t;

	typedef struct packed {
		logic [15:0] talker_code;
		logic [3:0]  msg_number;
		logic [3:0]  msg_total;
		logic [6:0]  msg_tracked;
		logic [6:0]  msg_snr_peak;
		logic [6:0]  view_count;
		logic [47:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [6:0] total_in_view;
		logic [6:0] total_tracked;
		logic [6:0] best_snr;
	} out_item_t;

	typedef struct packed {
		logic [15:0] talker;
		logic [47:0] expiry;
		logic [6:0]  in_view;
		logic [6:0]  run_tracked;
		logic [6:0]  run_snr;
		logic [6:0]  tracked;
		logic [6:0]  snr;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	function automatic logic [6:0] cap99(input logic [7:0] v);
		return (v > {1'b0, CAP99}) ? CAP99 : v[6:0];
	endfunction

endpackage

[hw/rtl/gsvt_ram.sv]
// ----------------------------------------------------------------------------
// GSVT generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gsvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/gnss_satellite_view_table.sv]
// ----------------------------------------------------------------------------
// GNSS satellite view table
// Per-talker GSV statistics held in a slot RAM, with totals over live slots.
// ----------------------------------------------------------------------------
// One item at a time. A sentence (nonzero talker) walks the slot RAM for a
// lookup, writes the updated slot back, walks the RAM again for the totals
// and then loads the result. A time-only item (talker zero) skips the lookup
// and write. Both walks go through the single read port of the slot RAM.
// in_ready returns the cycle after the result is loaded; a result that is not
// yet taken holds back only the loading of the next one. Valid bits stand in
// for clearing the RAM, so the block is ready right after reset. cfg_ready is
// always high; write the lifetime register only while no transaction is in
// progress.
module gnss_satellite_view_table #(
	parameter int SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gsvt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output gsvt_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  gsvt_pkg::lifetime_t cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                state_q;
	gsvt_pkg::lifetime_t   lifetime_q;
	gsvt_pkg::in_item_t    item_q;
	logic [47:0]           exp_q;
	logic [SLOTS-1:0]      vld_q;
	logic                  issue_q;
	logic [IW-1:0]         cnt_q;
	logic                  rd_vld_s1;
	logic                  ent_vld_s1;
	logic [IW-1:0]         idx_s1;
	logic                  hit_q;
	logic                  free_q;
	logic [IW-1:0]         hit_idx_q;
	logic [IW-1:0]         free_idx_q;
	logic [IW-1:0]         soon_idx_q;
	logic [47:0]           soon_exp_q;
	gsvt_pkg::slot_entry_t hit_ent_q;
	logic                  gn_q;
	logic [6:0]            gn_view_q;
	logic [6:0]            gn_trk_q;
	logic [6:0]            gn_snr_q;
	logic [6:0]            sum_view_q;
	logic [6:0]            sum_trk_q;
	logic [6:0]            peak_q;
	logic                  out_valid_q;
	gsvt_pkg::out_item_t   out_q;

	logic [gsvt_pkg::ENTRY_W-1:0] ram_rd_data;
	gsvt_pkg::slot_entry_t        ent;
	gsvt_pkg::slot_entry_t        base;
	gsvt_pkg::slot_entry_t        upd;
	logic [IW-1:0]                sel_idx;
	logic [48:0]                  exp_sum;
	logic [47:0]                  exp_sat;
	logic                         ent_live;
	logic                         out_load;
	logic                         first_msg;
	logic                         commit;
	logic [6:0]                   run_trk;
	logic [6:0]                   run_snr;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Saturating expiry for the accepted item.
	assign exp_sum = {1'b0, in_item.time_ms} + 49'(lifetime_q);
	assign exp_sat = exp_sum[48] ? '1 : exp_sum[47:0];

	// Entries never written read as all zeros.
	assign ent = ent_vld_s1 ? gsvt_pkg::slot_entry_t'(ram_rd_data) : '0;
	assign ent_live = (ent.talker != gsvt_pkg::TALKER_NONE) && (item_q.time_ms < ent.expiry);

	always_comb begin
		priority if (hit_q) begin
			sel_idx = hit_idx_q;
		end else if (free_q) begin
			sel_idx = free_idx_q;
		end else begin
			sel_idx = soon_idx_q;
		end
	end

	// Build the updated slot; a claimed slot starts from zero.
	always_comb begin
		base        = hit_q ? hit_ent_q : '0;
		first_msg   = (item_q.msg_number <= 4'd1);
		commit      = (item_q.msg_total == 4'd0) || (item_q.msg_number >= item_q.msg_total);
		run_trk     = first_msg ? 7'd0 : base.run_tracked;
		run_snr     = first_msg ? 7'd0 : base.run_snr;
		upd         = base;
		upd.talker  = item_q.talker_code;
		upd.expiry  = exp_q;
		upd.in_view = item_q.view_count;
		upd.run_tracked = gsvt_pkg::cap99({1'b0, run_trk} + {1'b0, item_q.msg_tracked});
		upd.run_snr = (item_q.msg_snr_peak > run_snr) ? item_q.msg_snr_peak : run_snr;
		if (commit) begin
			upd.tracked = upd.run_tracked;
			upd.snr     = upd.run_snr;
		end
	end

	gsvt_ram #(
		.WIDTH (gsvt_pkg::ENTRY_W),
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (state_q == ST_WRITE),
		.wr_addr (sel_idx),
		.wr_data (upd),
		.rd_en   (issue_q),
		.rd_addr (cnt_q),
		.rd_data (ram_rd_data)
	);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lifetime_q  <= gsvt_pkg::LIFETIME_INIT;
			vld_q       <= '0;
			issue_q     <= 1'b0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			gn_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				lifetime_q <= cfg_data;
			end
			rd_vld_s1 <= issue_q;
			if (issue_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_item.talker_code != gsvt_pkg::TALKER_NONE) ?
							ST_SCAN : ST_SUM;
						issue_q <= 1'b1;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						gn_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (!hit_q && ent.talker == item_q.talker_code) begin
							hit_q <= 1'b1;
						end
						if (!free_q && ent.talker == gsvt_pkg::TALKER_NONE) begin
							free_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					vld_q[sel_idx] <= 1'b1;
					state_q        <= ST_SUM;
					issue_q        <= 1'b1;
					cnt_q          <= '0;
				end
				ST_SUM: begin
					if (rd_vld_s1) begin
						if (ent_live && ent.talker == gsvt_pkg::TALKER_GN) begin
							gn_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		idx_s1     <= cnt_q;
		ent_vld_s1 <= vld_q[cnt_q];
		if (in_valid && in_ready) begin
			item_q     <= in_item;
			exp_q      <= exp_sat;
			sum_view_q <= '0;
			sum_trk_q  <= '0;
			peak_q     <= '0;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (!hit_q && ent.talker == item_q.talker_code) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= ent;
			end
			if (!free_q && ent.talker == gsvt_pkg::TALKER_NONE) begin
				free_idx_q <= idx_s1;
			end
			// Strict compare keeps the lowest index on a tie.
			if (idx_s1 == '0 || ent.expiry < soon_exp_q) begin
				soon_idx_q <= idx_s1;
				soon_exp_q <= ent.expiry;
			end
		end
		if (state_q == ST_SUM && rd_vld_s1 && ent_live) begin
			if (ent.talker == gsvt_pkg::TALKER_GN) begin
				gn_view_q <= ent.in_view;
				gn_trk_q  <= ent.tracked;
				gn_snr_q  <= ent.snr;
			end else begin
				sum_view_q <= gsvt_pkg::cap99({1'b0, sum_view_q} + {1'b0, ent.in_view});
				sum_trk_q  <= gsvt_pkg::cap99({1'b0, sum_trk_q} + {1'b0, ent.tracked});
				if (ent.snr > peak_q) begin
					peak_q <= ent.snr;
				end
			end
		end
		if (out_load) begin
			if (gn_q) begin
				out_q.total_in_view <= gsvt_pkg::cap99({1'b0, gn_view_q});
				out_q.total_tracked <= gsvt_pkg::cap99({1'b0, gn_trk_q});
				out_q.best_snr      <= gsvt_pkg::cap99({1'b0, gn_snr_q});
			end else begin
				out_q.total_in_view <= sum_view_q;
				out_q.total_tracked <= sum_trk_q;
				out_q.best_snr      <= gsvt_pkg::cap99({1'b0, peak_q});
			end
		end
	end

endmodule

[hw/rtl/gsvt_checker.sv]
// ----------------------------------------------------------------------------
// GSVT port checker
// Watches the top level's ports for result range and transaction ordering.
// ----------------------------------------------------------------------------
`include "gnss_satellite_view_table_defines.svh"

module gsvt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input gsvt_pkg::out_item_t out_item
);

	`GSVT_ASSERT_IMP(a_result_range, clk, arst_n, out_valid, (out_item.total_in_view <= gsvt_pkg::CAP99) && (out_item.total_tracked <= gsvt_pkg::CAP99) && (out_item.best_snr <= gsvt_pkg::CAP99), "result field above 99")
	`GSVT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready ##1 !in_ready, "input taken while a transaction is in progress")
	`GSVT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind gnss_satellite_view_table gsvt_checker u_gsvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GNSS satellite view table testbench
// Sends parsed GSV sentences and time-only ticks through the valid/ready
// ports. A behavioral slot table in this file predicts the totals after each
// transaction, and each result is checked against it in order. Stalls and gaps
// fall at random on both sides, and the slot lifetime moves through several
// values, among them zero and its largest.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SLOTS = 8;
	localparam int ITEM_CYCLES = 2 * SLOTS + 4;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] TALKER_GP = 16'h4750;
	localparam logic [15:0] TALKER_GL = 16'h474C;
	localparam logic [15:0] TALKER_GA = 16'h4741;
	localparam logic [15:0] TALKER_GB = 16'h4742;
	localparam logic [15:0] TALKER_GQ = 16'h4751;
	localparam logic [15:0] TALKER_BD = 16'h4244;
	localparam logic [15:0] TALKER_GI = 16'h4749;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	gsvt_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	gsvt_pkg::out_item_t out_item;
	logic                cfg_valid;
	logic                cfg_ready;
	gsvt_pkg::lifetime_t cfg_data;

	// behavioral copy of the slot table
	logic [15:0]         tbl_talker  [SLOTS];
	logic [47:0]         tbl_expiry  [SLOTS];
	logic [6:0]          tbl_in_view [SLOTS];
	logic [6:0]          tbl_run_trk [SLOTS];
	logic [6:0]          tbl_run_snr [SLOTS];
	logic [6:0]          tbl_trk     [SLOTS];
	logic [6:0]          tbl_snr     [SLOTS];
	gsvt_pkg::lifetime_t lifetime_ms;

	gsvt_pkg::out_item_t expected_totals[$];
	logic [47:0]         now_ms;
	int                  mismatch_count;
	bit                  steady;

	gnss_satellite_view_table #(
		.SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] clip99(input int v);
		return (v > int'(gsvt_pkg::CAP99)) ? gsvt_pkg::CAP99 : 7'(v);
	endfunction

	function automatic void wipe_slot(input int i);
		tbl_talker[i] = gsvt_pkg::TALKER_NONE;
		tbl_expiry[i] = '0;
		tbl_in_view[i] = '0;
		tbl_run_trk[i] = '0;
		tbl_run_snr[i] = '0;
		tbl_trk[i] = '0;
		tbl_snr[i] = '0;
	endfunction

	// Match the talker, even on a dead slot; else the first free slot; else
	// the slot that expires soonest, lowest index on a tie.
	function automatic int claim_slot(input logic [15:0] talker);
		int hit;
		int soonest;
		hit = -1;
		soonest = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && tbl_talker[i] == talker)
				hit = i;
			if (tbl_expiry[i] < tbl_expiry[soonest])
				soonest = i;
		end
		if (hit >= 0)
			return hit;
		for (int i = 0; i < SLOTS; i++)
			if (hit < 0 && tbl_talker[i] == gsvt_pkg::TALKER_NONE)
				hit = i;
		if (hit < 0)
			hit = soonest;
		wipe_slot(hit);
		tbl_talker[hit] = talker;
		return hit;
	endfunction

	function automatic gsvt_pkg::out_item_t predict_totals(input gsvt_pkg::in_item_t it);
		int                  s;
		int                  sum_view;
		int                  sum_trk;
		int                  peak;
		int                  gn_view;
		int                  gn_trk;
		int                  gn_snr;
		logic                gn_live;
		logic [48:0]         exp_sum;
		gsvt_pkg::out_item_t res;
		if (it.talker_code != gsvt_pkg::TALKER_NONE) begin
			s = claim_slot(it.talker_code);
			if (it.msg_number <= 4'd1) begin
				tbl_run_trk[s] = '0;
				tbl_run_snr[s] = '0;
			end
			tbl_run_trk[s] = clip99(int'(tbl_run_trk[s]) + int'(it.msg_tracked));
			if (it.msg_snr_peak > tbl_run_snr[s])
				tbl_run_snr[s] = it.msg_snr_peak;
			tbl_in_view[s] = it.view_count;
			exp_sum = {1'b0, it.time_ms} + 49'(lifetime_ms);
			tbl_expiry[s] = exp_sum[48] ? TIME_MAX : exp_sum[47:0];
			if (it.msg_total == 4'd0 || it.msg_number >= it.msg_total) begin
				tbl_trk[s] = tbl_run_trk[s];
				tbl_snr[s] = tbl_run_snr[s];
			end
		end
		sum_view = 0;
		sum_trk = 0;
		peak = 0;
		gn_live = 1'b0;
		gn_view = 0;
		gn_trk = 0;
		gn_snr = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_talker[i] != gsvt_pkg::TALKER_NONE && it.time_ms < tbl_expiry[i]) begin
				if (tbl_talker[i] == gsvt_pkg::TALKER_GN) begin
					gn_live = 1'b1;
					gn_view = int'(tbl_in_view[i]);
					gn_trk = int'(tbl_trk[i]);
					gn_snr = int'(tbl_snr[i]);
				end else begin
					sum_view = int'(clip99(sum_view + int'(tbl_in_view[i])));
					sum_trk = int'(clip99(sum_trk + int'(tbl_trk[i])));
					if (int'(tbl_snr[i]) > peak)
						peak = int'(tbl_snr[i]);
				end
			end
		end
		// a live combined talker replaces the per-system sums
		if (gn_live) begin
			sum_view = gn_view;
			sum_trk = gn_trk;
			peak = gn_snr;
		end
		res.total_in_view = clip99(sum_view);
		res.total_tracked = clip99(sum_trk);
		res.best_snr = clip99(peak);
		return res;
	endfunction

	function automatic gsvt_pkg::in_item_t mk_item(input logic [15:0] talker,
			input logic [3:0] num, input logic [3:0] total, input logic [6:0] trk,
			input logic [6:0] snr, input logic [6:0] view, input logic [47:0] t);
		gsvt_pkg::in_item_t it;
		it.talker_code = talker;
		it.msg_number = num;
		it.msg_total = total;
		it.msg_tracked = trk;
		it.msg_snr_peak = snr;
		it.view_count = view;
		it.time_ms = t;
		return it;
	endfunction

	function automatic logic [15:0] pick_talker();
		case ($urandom_range(0, 9))
			0, 8: return TALKER_GP;
			1, 9: return TALKER_GL;
			2: return TALKER_GA;
			3: return TALKER_GB;
			4: return TALKER_GQ;
			5: return TALKER_BD;
			6: return TALKER_GI;
			default: return gsvt_pkg::TALKER_GN;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly sentence spacing; now and then a jump long enough to expire slots.
	function automatic void advance_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			now_ms += 48'($urandom_range(1, 150));
		else if (r < 90)
			now_ms += 48'($urandom_range(1, 2 * int'(lifetime_ms) + 10));
	endfunction

	task automatic send_item(input gsvt_pkg::in_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_totals.push_back(predict_totals(it));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES) @(posedge clk);
	endtask

	task automatic write_lifetime(input gsvt_pkg::lifetime_t value);
		drain();
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		lifetime_ms = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_table_basics();
		// empty table
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, 48'd0));
		send_item(mk_item(TALKER_GP, 0, 0, 5, 40, 10, 48'd1000));
		// running sums stay hidden until the last message
		send_item(mk_item(TALKER_GL, 1, 3, 4, 30, 12, 48'd1010));
		send_item(mk_item(TALKER_GL, 2, 3, 3, 45, 12, 48'd1020));
		send_item(mk_item(TALKER_GL, 3, 3, 2, 20, 12, 48'd1030));
		send_item(mk_item(TALKER_GA, 0, 2, 7, 33, 9, 48'd1040));
		send_item(mk_item(TALKER_GA, 5, 2, 1, 38, 9, 48'd1050));
		// out-of-range counts: saturate sums, clip reports
		send_item(mk_item(TALKER_GB, 15, 15, 127, 127, 127, 48'd1060));
		send_item(mk_item(TALKER_GB, 1, 0, 0, 0, 0, 48'd1070));
		send_item(mk_item(TALKER_GB, 2, 2, 127, 1, 99, 48'd1080));
		send_item(mk_item(gsvt_pkg::TALKER_GN, 1, 1, 20, 35, 25, 48'd1090));
		send_item(mk_item(TALKER_GQ, 1, 1, 3, 28, 6, 48'd1100));
		send_item(mk_item(TALKER_BD, 1, 1, 8, 41, 14, 48'd1100));
		send_item(mk_item(TALKER_GI, 1, 1, 2, 22, 4, 48'd1100));
		// table full: reclaim the soonest expiring slots
		send_item(mk_item(16'hFFFF, 1, 1, 6, 50, 8, 48'd1200));
		send_item(mk_item(16'h0001, 1, 1, 1, 10, 2, 48'd1200));
		// combined talker dies, then the last batch reaches its expiry exactly
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, 48'd6090));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 15, 15, 127, 127, 127, 48'd6100));
		// a dead slot is still found by its talker
		send_item(mk_item(TALKER_GQ, 2, 2, 4, 30, 6, 48'd6150));
		send_item(mk_item(16'h0002, 1, 1, 9, 31, 11, 48'd6150));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, 48'd6200));
		now_ms = 48'd6200;
	endtask

	task automatic test_gsv_traffic(input gsvt_pkg::lifetime_t lifetime, input int n_items);
		int                 sent;
		int                 r;
		int                 total;
		int                 first;
		int                 last;
		logic [15:0]        talker;
		logic [6:0]         view;
		gsvt_pkg::in_item_t it;
		write_lifetime(lifetime);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0)
				steady = ~steady;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// one GSV cycle, sometimes entered late or broken off
				talker = pick_talker();
				total = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
				view = 7'($urandom_range(4, 20));
				last = (total == 0) ? 1 : total;
				first = ($urandom_range(0, 9) == 0) ? last : 1;
				if ($urandom_range(0, 9) == 0)
					last = $urandom_range(first, last);
				for (int m = first; m <= last; m++) begin
					advance_time();
					send_item(mk_item(talker, 4'(m), 4'(total), 7'($urandom_range(0, 12)),
						7'($urandom_range(15, 55)), view, now_ms));
					sent++;
				end
			end else if (r < 85) begin
				advance_time();
				it = mk_item(gsvt_pkg::TALKER_NONE, 4'($urandom()), 4'($urandom()),
					7'($urandom()), 7'($urandom()), 7'($urandom()), now_ms);
				if ($urandom_range(0, 7) == 0)
					it.time_ms = 48'({$urandom(), $urandom()});
				send_item(it);
				sent++;
			end else begin
				advance_time();
				talker = ($urandom_range(0, 3) == 0) ? pick_talker() : 16'($urandom());
				it = mk_item(talker, 4'($urandom()), 4'($urandom()), 7'($urandom()),
					7'($urandom()), 7'($urandom()), now_ms);
				if (now_ms > 48'd500 && $urandom_range(0, 4) == 0)
					it.time_ms = now_ms - 48'($urandom_range(1, 500));
				send_item(it);
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_lifetime_extremes();
		write_lifetime('0);
		now_ms += 100;
		send_item(mk_item(TALKER_GP, 1, 1, 6, 44, 9, now_ms));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, now_ms));
		write_lifetime(20'd1);
		now_ms += 100;
		send_item(mk_item(TALKER_GL, 0, 0, 5, 37, 8, now_ms));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, now_ms));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, now_ms + 48'd1));
		// expiry saturates at the top of the time range
		write_lifetime(20'hFFFFF);
		send_item(mk_item(TALKER_GA, 1, 1, 7, 42, 10, TIME_MAX - 48'd16));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, TIME_MAX - 48'd1));
		send_item(mk_item(gsvt_pkg::TALKER_NONE, 0, 0, 0, 0, 0, TIME_MAX));
		send_item(mk_item(gsvt_pkg::TALKER_GN, 1, 1, 11, 39, 13, TIME_MAX));
	endtask

	function automatic void check_field(input string name, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 100)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : totals_check
		gsvt_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_totals.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, got %0d/%0d/%0d", $time,
					out_item.total_in_view, out_item.total_tracked, out_item.best_snr);
			end else begin
				want = expected_totals.pop_front();
				check_field("total_in_view", want.total_in_view, out_item.total_in_view);
				check_field("total_tracked", want.total_tracked, out_item.total_tracked);
				check_field("best_snr", want.best_snr, out_item.best_snr);
			end
		end
	end

	initial begin : result_sink
		int hold;
		out_ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (steady || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				hold = steady ? 0 : $urandom_range(0, 6);
			end else begin
				out_ready <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		steady = 1'b0;
		now_ms = '0;
		lifetime_ms = gsvt_pkg::LIFETIME_INIT;
		for (int i = 0; i < SLOTS; i++)
			wipe_slot(i);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_table_basics();
		test_gsv_traffic(20'd800, 330);
		test_gsv_traffic(20'd1, 120);
		test_gsv_traffic(20'd3000, 330);
		test_gsv_traffic(20'd600000, 300);
		test_gsv_traffic(gsvt_pkg::lifetime_t'($urandom_range(200, 20000)), 330);
		test_lifetime_extremes();
		drain();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gsvt_pkg.sv
hw/rtl/gsvt_ram.sv
hw/rtl/gnss_satellite_view_table.sv
hw/rtl/gsvt_checker.sv
tb/tb_top.sv
